@@ rtl/core/sha256_stream_hasher_core_macros.svh @@
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH

// Same-cycle implication.
`define S256H_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define S256H_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/s256h_pkg.sv @@
// ---------------------------------------------------------------------------
// s256h_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
`default_nettype none

package s256h_pkg;

  localparam int LEN_BITS_DEFAULT = 64;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_SLOT  = 6'd56;
  localparam logic [5:0] LAST_SLOT = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_PART = 2'd3;

  typedef logic [0:7][31:0] s256h_hash_t;

  localparam s256h_hash_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the sequencer to the compression unit.
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       start;
    logic       reload;
  } s256h_ctrl_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FOLD
  } s256h_cstate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSG_WAIT,
    S_PAD,
    S_ZERO,
    S_PAD_WAIT,
    S_LEN,
    S_LEN_WAIT,
    S_OUT
  } s256h_state_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/s256h_compress.sv @@
// ---------------------------------------------------------------------------
// s256h_compress
// Block window, chaining value and one SHA-256 round per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module s256h_compress (
  input  wire                       clk,
  input  wire                       rst,
  input  s256h_pkg::s256h_ctrl_t    ctrl,
  output logic                      done,
  output s256h_pkg::s256h_hash_t    chain
);
  import s256h_pkg::*;

  s256h_cstate_t state, state_next;
  logic [5:0]    rnd;
  s256h_hash_t   v, v_round;
  logic [511:0]  window;
  logic [31:0]   t1, t2, w_new;

  // Window word 0 is w[t]; words 0, 1, 9 and 14 feed w[t+16].
  always_comb begin
    t1 = v[7] + big_sigma1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[rnd]
         + window[511:480];
    t2 = big_sigma0(v[0]) + majority(v[0], v[1], v[2]);
    v_round = {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    w_new = small_sigma1(window[63:32]) + window[223:192]
            + small_sigma0(window[479:448]) + window[511:480];
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      C_IDLE: begin
        if (ctrl.start) state_next = C_ROUND;
      end
      C_ROUND: begin
        if (rnd == LAST_ROUND) state_next = C_FOLD;
      end
      C_FOLD: begin
        done = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      chain <= INIT_HASH;
      rnd   <= '0;
    end else begin
      state <= state_next;
      case (state)
        C_IDLE: begin
          rnd <= '0;
          if (ctrl.reload) chain <= INIT_HASH;
        end
        C_ROUND: rnd <= rnd + 6'd1;
        C_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
        end
        default: rnd <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (ctrl.shift) window <= {window[503:0], ctrl.data};
        if (ctrl.start) v <= chain;
      end
      C_ROUND: begin
        v      <= v_round;
        window <= {window[479:0], w_new};
      end
      default: v <= v;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256_stream_hasher_core.sv @@
// ---------------------------------------------------------------------------
// sha256_stream_hasher_core
// Byte-stream SHA-256 hasher with padding and four-part digest output.
// ---------------------------------------------------------------------------
// Feed a message one item at a time: s_tdata carries a byte, s_tuser says the
// byte is present, s_tlast ends the message after that byte. A byte that does
// not complete a 64-byte block or end the message leaves s_tready high. A
// byte that completes a block holds s_tready low while the single shared
// round unit runs the 64 rounds and then folds the result into the chaining
// value. On end of message the sequencer appends 0x80, zero bytes and the
// 64-bit bit length one byte at a time, running one or two further
// compressions, then presents the digest as four 64-bit items, most
// significant first, and reloads the initial hash for the next message.
// s_tready is low from end of message until the last digest item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_core #(
  parameter int LENGTH_COUNTER_BITS = s256h_pkg::LEN_BITS_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // [7:0] byte_value
  input  wire          s_tuser,   // [0] has_byte
  input  wire          s_tlast,   // end_of_message
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [63:0]  m_tdata,   // [63:0] digest_part
  output logic [1:0]   m_tuser,   // [1:0] part_index
  output logic         m_tlast    // last_part
);
  import s256h_pkg::*;

  s256h_state_t state, state_next;
  logic [5:0]   fill, fill_next;           // bytes in the current block
  logic [LENGTH_COUNTER_BITS-1:0] byte_total, byte_total_next;
  logic         extra, extra_next;         // length needs one more block
  logic         fin, fin_next;             // message ends after this block
  logic [1:0]   part, part_next;
  s256h_ctrl_t  ctrl;
  logic         done;
  s256h_hash_t  chain;
  logic [63:0]  bit_len, len_shift;

  s256h_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .done  (done),
    .chain (chain)
  );

  // Bit length, big-endian; the low three fill bits pick the byte in the
  // length slots.
  assign bit_len   = 64'(byte_total) << 3;
  assign len_shift = bit_len << {fill[2:0], 3'b000};

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {chain[{part, 1'b0}], chain[{part, 1'b1}]};
  assign m_tuser  = part;
  assign m_tlast  = (part == LAST_PART);

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    byte_total_next = byte_total;
    extra_next      = extra;
    fin_next        = fin;
    part_next       = part;
    ctrl            = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            // absorb the byte first, then handle end of message
            ctrl.shift      = 1'b1;
            ctrl.data       = s_tdata;
            fill_next       = fill + 6'd1;
            byte_total_next = byte_total + LENGTH_COUNTER_BITS'(1);
          end
          if (s_tuser && fill == LAST_SLOT) begin
            ctrl.start = 1'b1;
            fin_next   = s_tlast;
            state_next = S_MSG_WAIT;
          end else if (s_tlast) begin
            state_next = S_PAD;
          end
        end
      end
      S_MSG_WAIT: begin
        if (done) state_next = fin ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        ctrl.shift = 1'b1;
        ctrl.data  = PAD_BYTE;
        fill_next  = fill + 6'd1;
        if (fill == LAST_SLOT) begin
          ctrl.start = 1'b1;
          extra_next = 1'b0;
          state_next = S_PAD_WAIT;
        end else begin
          // marker in the length slots: length goes in a further block
          extra_next = (fill >= LEN_SLOT);
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill == LEN_SLOT && !extra) begin
          state_next = S_LEN;
        end else begin
          ctrl.shift = 1'b1;
          ctrl.data  = '0;
          fill_next  = fill + 6'd1;
          if (fill == LAST_SLOT) begin
            ctrl.start = 1'b1;
            extra_next = 1'b0;
            state_next = S_PAD_WAIT;
          end
        end
      end
      S_PAD_WAIT: begin
        if (done) state_next = S_ZERO;
      end
      S_LEN: begin
        ctrl.shift = 1'b1;
        ctrl.data  = len_shift[63:56];
        fill_next  = fill + 6'd1;
        if (fill == LAST_SLOT) begin
          ctrl.start = 1'b1;
          state_next = S_LEN_WAIT;
        end
      end
      S_LEN_WAIT: begin
        if (done) begin
          part_next  = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          part_next = part + 2'd1;
          if (part == LAST_PART) begin
            // drop the digest and start the next message fresh
            ctrl.reload     = 1'b1;
            byte_total_next = '0;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      byte_total <= '0;
      extra      <= 1'b0;
      fin        <= 1'b0;
      part       <= '0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      byte_total <= byte_total_next;
      extra      <= extra_next;
      fin        <= fin_next;
      part       <= part_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/s256h_checker.sv @@
// ---------------------------------------------------------------------------
// s256h_checker
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_core_macros.svh"

module s256h_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire       s_tlast,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [1:0] m_tuser,
  input wire       m_tlast
);

  // No new item is taken while the digest is out.
  `S256H_ASSERT_SAME(a_no_input_during_output, m_tvalid, !s_tready, "input ready during digest output")

  // An accepted end of message drops s_tready.
  `S256H_ASSERT_NEXT(a_end_stalls_input, s_tvalid && s_tready && s_tlast, !s_tready, "ready right after end of message")

  // Parts come in order, starting from zero.
  `S256H_ASSERT_SAME(a_first_part_zero, $rose(m_tvalid), m_tuser == 2'd0, "digest does not start at part 0")

  `S256H_ASSERT_NEXT(a_part_advance, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == ($past(m_tuser) + 2'd1)), "digest part skipped")

  // The last part closes the digest.
  `S256H_ASSERT_NEXT(a_last_closes, m_tvalid && m_tready && m_tlast, !m_tvalid, "output continues after last part")

endmodule

bind sha256_stream_hasher_core s256h_checker u_s256h_checker (.*);

`default_nettype wire

@@ tb/sv/sha256_stream_hasher_core_tb.sv @@
// ---------------------------------------------------------------------------
// sha256_stream_hasher_core_tb
// Self-checking bench for the byte-stream SHA-256 hasher. Messages go in one
// byte per item with random gaps. An in-bench SHA-256 predictor computes the
// four digest items that each end of message must produce. The output side
// stalls at random, and every digest item is checked in order against the
// prediction.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 300;
  localparam int CALM_TAIL    = 40;

  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int         LEN_OFFSET = 56;
  localparam int         LAST_IDX = 63;

  typedef struct {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_msg;
    logic       drain_first;  // hold this item until no digest item is outstanding
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic [1:0]  index;
    logic        is_last;
  } digest_part_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] byte_value
  logic        s_tuser = 1'b0; // [0] has_byte
  logic        s_tlast = 1'b0; // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [63:0] digest_part
  logic [1:0]  m_tuser;        // [1:0] part_index
  logic        m_tlast;        // last_part

  sha256_stream_hasher_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Stimulus and expectation stores.
  msg_item_t    message_items[$];
  digest_part_t expected_digest_parts[$];

  // Predictor state: chaining value, 64-byte block and message byte count.
  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_byte_count;

  int stim_count;
  int msg_count;
  int items_total;
  int items_taken;
  int err_count;
  int cycle_count;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds on the current block and fold into the chaining value.
  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic sha_restart();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    msg_byte_count = '0;
  endtask

  // Absorb one accepted item; on end of message queue the four digest items.
  task automatic sha_absorb_item(input msg_item_t it);
    int          slot;
    logic [63:0] bit_len;
    digest_part_t dp;
    if (it.has_byte) begin
      slot = int'(msg_byte_count[5:0]);
      block_bytes[slot] = it.byte_value;
      msg_byte_count = msg_byte_count + 64'd1;
      if (slot == LAST_IDX) sha_compress();
    end
    if (it.end_msg) begin
      slot = int'(msg_byte_count[5:0]);
      bit_len = msg_byte_count << 3;
      block_bytes[slot] = PAD_MARK;
      for (int i = slot + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room for the length: close this block and pad a fresh one.
      if (slot >= LEN_OFFSET) begin
        sha_compress();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      sha_compress();
      for (int k = 0; k < 4; k++) begin
        dp.word    = {chain_h[2*k], chain_h[2*k+1]};
        dp.index   = k[1:0];
        dp.is_last = (k == 3);
        expected_digest_parts.push_back(dp);
      end
      sha_restart();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic has, input logic eom,
                           input logic drain);
    msg_item_t it;
    it.byte_value  = b;
    it.has_byte    = has;
    it.end_msg     = eom;
    it.drain_first = drain;
    message_items.push_back(it);
    if (has || eom) stim_count++;
  endtask

  // Random-content message; the end rides on the last byte or comes alone.
  task automatic push_message(input int len, input logic drain);
    logic joined;
    joined = ($urandom_range(0, 1) == 1) && (len != 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1),
                drain && (i == 0));
    end
    if (!joined) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
    msg_count++;
  endtask

  function automatic logic calm_phase();
    return message_items.size() < CALM_TAIL;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: present items from message_items, idle in random bursts
  // --------------------------------------------------------------------------
  msg_item_t drv_item;
  int        drv_gap;
  logic      drv_fire;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      drv_fire = s_tvalid && s_tready;
      if (drv_fire) begin
        sha_absorb_item(drv_item);
        items_taken++;
      end
      if (s_tvalid && !drv_fire) begin
        // hold the item until the block takes it
      end else if (drv_gap != 0) begin
        drv_gap--;
        s_tvalid <= 1'b0;
      end else if (message_items.size() == 0 ||
                   (message_items[0].drain_first && expected_digest_parts.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
        // start an idle burst; drv_gap counts it down
        drv_gap = $urandom_range(0, 8);
        s_tvalid <= 1'b0;
      end else begin
        drv_item = message_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= drv_item.byte_value;
        s_tuser  <= drv_item.has_byte;
        s_tlast  <= drv_item.end_msg;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall m_tready in bursts, check each digest item in order
  // --------------------------------------------------------------------------
  digest_part_t mon_exp;
  int           mon_stall;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      mon_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_digest_parts.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected digest item: part %0d data %h last %b",
                     m_tuser, m_tdata, m_tlast);
        end else begin
          mon_exp = expected_digest_parts.pop_front();
          if (m_tdata !== mon_exp.word || m_tuser !== mon_exp.index ||
              m_tlast !== mon_exp.is_last) begin
            err_count++;
            if (err_count <= 10)
              $display("digest mismatch: expected part %0d %h last %b, got part %0d %h last %b",
                       mon_exp.index, mon_exp.word, mon_exp.is_last,
                       m_tuser, m_tdata, m_tlast);
          end
        end
      end
      if (mon_stall != 0) begin
        mon_stall--;
        m_tready <= 1'b0;
      end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
        mon_stall = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha256_stream_hasher_core_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int len;
    stim_count  = 0;
    msg_count   = 0;
    items_taken = 0;
    err_count   = 0;
    cycle_count = 0;
    sha_restart();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

    // Directed: empty message right after reset.
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    // Ignored item with all data bits set.
    push_item(8'hff, 1'b0, 1'b0, 1'b0);
    // "abc" with the end riding on the last byte; wait for the block to drain first.
    push_item(8'h61, 1'b1, 1'b0, 1'b1);
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    // Extreme byte values, then an end with no byte.
    push_item(8'h00, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    // Ignored item in the middle of a message.
    push_item(8'h5a, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0, 1'b0);
    push_item(8'ha5, 1'b1, 1'b1, 1'b0);
    msg_count += 4;

    // Padding boundaries: length just fits, length spills to a second block.
    push_message(55, 1'b0);
    push_message(56, 1'b0);
    // Random messages, mostly short, sometimes on a block boundary.
    while (stim_count < 200 || msg_count < 12) begin
      case ($urandom_range(0, 11))
        0:       len = 63;
        1:       len = 64;
        2:       len = 65;
        3:       len = 119 + $urandom_range(0, 1);
        default: len = $urandom_range(0, 24);
      endcase
      push_message(len, $urandom_range(0, 7) == 0);
    end
    items_total = message_items.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every digest item to arrive.
    while (items_taken != items_total) @(posedge clk);
    while (expected_digest_parts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_digest_parts.size() != 0)
      $display("%0d digest items never arrived", expected_digest_parts.size());
    if (err_count == 0 && expected_digest_parts.size() == 0) begin
      $display("sha256_stream_hasher_core_tb: clean");
    end else begin
      $display("sha256_stream_hasher_core_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/s256h_pkg.sv
rtl/core/s256h_compress.sv
rtl/core/sha256_stream_hasher_core.sv
rtl/core/s256h_checker.sv
tb/sv/sha256_stream_hasher_core_tb.sv
